// File: rtl/core/renc_pkg.sv
// renc_pkg: shared types and constants of the rotary encoder to MIDI CC block
// used by renc_lane, renc_merge and rotary_encoder_to_midi_cc
// no dependencies
package renc_pkg;

    // widths and fixed values
    localparam int ENC_MAX  = 4;
    localparam int PIN_W    = 8;
    localparam int POS_W    = 15;
    localparam int STEP_W   = 13;
    localparam int CC_W     = 7;
    localparam int CHAN_W   = 4;
    localparam int IDX_W    = 2;

    localparam logic [POS_W-1:0]  POS_MAX   = 15'd32512;
    localparam logic [POS_W-1:0]  POS_RESET = 15'd16256;
    localparam logic [7:0]        CC_STATUS = 8'hB0;
    localparam logic [PIN_W-1:0]  PINS_RESET = 8'hFF;

    // pin pair codes that count as a detent
    localparam logic [1:0] PAIR_LOW  = 2'b00;
    localparam logic [1:0] PAIR_HIGH = 2'b10;

    // register reset values
    localparam logic [CC_W-1:0]   CC0_RESET  = 7'd44;
    localparam logic [CC_W-1:0]   CC1_RESET  = 7'd46;
    localparam logic [CC_W-1:0]   CC2_RESET  = 7'd48;
    localparam logic [CC_W-1:0]   CC3_RESET  = 7'd53;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RESET = 13'd1357;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_CC0     = 3'd0,
        REG_CC1     = 3'd1,
        REG_CC2     = 3'd2,
        REG_CC3     = 3'd3,
        REG_CHANNEL = 3'd4,
        REG_STEP    = 3'd5
    } reg_idx_t;

    // configuration seen by the merge stage
    typedef struct packed {
        logic [ENC_MAX-1:0][CC_W-1:0] cc;
        logic [CHAN_W-1:0]            channel;
    } cfg_t;

    // per-lane status toward the merge stage
    typedef struct packed {
        logic            moved;
        logic [CC_W-1:0] value;
    } lane_stat_t;

endpackage

// File: rtl/core/renc_lane.sv
// renc_lane: one encoder lane, detent detection and clamped Q7.8 position
// depends on renc_pkg
module renc_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [1:0]                    pair_before,
    input  logic [1:0]                    pair_now,
    input  logic [renc_pkg::STEP_W-1:0]   step,
    output renc_pkg::lane_stat_t          stat
);

    logic [renc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [renc_pkg::POS_W:0]   sum;
    logic                       down, up;

    // detent direction from the pin pair change
    assign down = (pair_before == renc_pkg::PAIR_LOW)  && (pair_now == renc_pkg::PAIR_HIGH);
    assign up   = (pair_before == renc_pkg::PAIR_HIGH) && (pair_now == renc_pkg::PAIR_LOW);
    assign sum  = {1'b0, pos_reg} + {3'b000, step};

    // saturating position update
    always_comb begin
        pos_next = pos_reg;
        if (accept && down) begin
            if ({2'b00, step} > pos_reg) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg - {2'b00, step};
            end
        end else if (accept && up) begin
            if (sum > {1'b0, renc_pkg::POS_MAX}) begin
                pos_next = renc_pkg::POS_MAX;
            end else begin
                pos_next = sum[renc_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= renc_pkg::POS_RESET;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // integer part of the current position
    assign stat.moved = down | up;
    assign stat.value = pos_reg[renc_pkg::POS_W-1:8];

    // position never leaves 0..127.0
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= renc_pkg::POS_MAX)
        else $error("encoder position above full scale");

endmodule

// File: rtl/core/renc_merge.sv
// renc_merge: pending-mask serializer that turns moved lanes into CC messages
// depends on renc_pkg
module renc_merge (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      accept,
    input  renc_pkg::lane_stat_t [renc_pkg::ENC_MAX-1:0] lane_stat,
    input  renc_pkg::cfg_t                            cfg,
    output logic                                      take_ready,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [23:0]                               m_tdata,
    output logic                                      m_tlast
);

    logic [renc_pkg::ENC_MAX-1:0] mask_reg, mask_next, mask_after, new_mask, clr;
    logic [renc_pkg::IDX_W-1:0]   sel;
    logic                         out_load, emit, last;

    logic                         m_valid_reg;
    logic                         m_last_reg;
    logic [renc_pkg::IDX_W-1:0]   idx_reg;
    logic [7:0]                   status_reg;
    logic [renc_pkg::CC_W-1:0]    cc_reg;
    logic [renc_pkg::CC_W-1:0]    value_reg;

    // moved lanes of the sample being accepted
    always_comb begin
        for (int k = 0; k < renc_pkg::ENC_MAX; k++) begin
            new_mask[k] = lane_stat[k].moved;
        end
    end

    // lowest pending lane goes first
    always_comb begin
        sel = '0;
        for (int k = renc_pkg::ENC_MAX - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                sel = renc_pkg::IDX_W'(k);
            end
        end
    end

    assign clr        = renc_pkg::ENC_MAX'(1) << sel;
    assign out_load   = !m_valid_reg || m_tready;
    assign emit       = (mask_reg != '0) && out_load;
    assign mask_after = emit ? (mask_reg & ~clr) : mask_reg;
    assign last       = (mask_reg & ~clr) == '0;
    assign take_ready = mask_after == '0;
    assign mask_next  = accept ? new_mask : mask_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (out_load) begin
                m_valid_reg <= emit;
            end
        end
    end

    // message fields for the output register
    always_ff @(posedge aclk) begin
        if (emit) begin
            idx_reg    <= sel;
            status_reg <= renc_pkg::CC_STATUS | {4'b0000, cfg.channel};
            cc_reg     <= cfg.cc[sel];
            value_reg  <= lane_stat[sel].value;
            m_last_reg <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {value_reg, cc_reg, status_reg, idx_reg};

    // an unfinished run still has lanes pending
    a_run_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (mask_reg != '0))
        else $error("run cut short without a last message");

    // messages of one run leave in rising encoder order
    a_run_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tready && !m_last_reg) |=>
            (m_valid_reg && (idx_reg > $past(idx_reg))))
        else $error("messages out of encoder order");

    // no new sample while lanes of the current one are waiting
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (mask_after == '0))
        else $error("sample accepted over pending messages");

endmodule

// File: rtl/core/rotary_encoder_to_midi_cc.sv
// rotary_encoder_to_midi_cc: top level, APB registers, encoder lanes and merge
// depends on renc_pkg, renc_lane and renc_merge
// Takes one 8-bit pin sample per transfer (two pins per encoder) and sends
// one MIDI control-change message per encoder that moved a detent, lowest
// encoder first, with tlast on the final message of that sample. A sample
// that moves no more than one encoder is taken every cycle while the output
// can load; one that moves more (up to 4) holds the input while the single
// output register drains the pending lanes, one message per cycle while
// m_tready allows. A stalled result does not block the next sample: it is
// taken as soon as the last pending message of the previous one loads the
// output register. The registers sit at byte addresses 0, 4, 8, 12
// (controller numbers), 16 (channel) and 20 (step, unsigned Q5.8)
// and are to be written only while idle; the block does not enforce it.
module rotary_encoder_to_midi_cc #(
    parameter int ENCODER_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pin_sample[7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // encoder_index[1:0], status_byte[9:2], controller_number[16:10],
    // control_value[23:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [renc_pkg::PIN_W-1:0]  prev_pins_reg;
    logic [renc_pkg::STEP_W-1:0] step_reg;
    renc_pkg::cfg_t              cfg_reg;
    renc_pkg::reg_idx_t          widx;
    logic                        wr_en, accept, take_ready;
    renc_pkg::lane_stat_t [renc_pkg::ENC_MAX-1:0] lane_stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = renc_pkg::reg_idx_t'(paddr[4:2]);

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cc[0]   <= renc_pkg::CC0_RESET;
            cfg_reg.cc[1]   <= renc_pkg::CC1_RESET;
            cfg_reg.cc[2]   <= renc_pkg::CC2_RESET;
            cfg_reg.cc[3]   <= renc_pkg::CC3_RESET;
            cfg_reg.channel <= renc_pkg::CHAN_RESET;
            step_reg        <= renc_pkg::STEP_RESET;
        end else if (wr_en) begin
            unique case (widx)
                renc_pkg::REG_CC0:     cfg_reg.cc[0]   <= pwdata[renc_pkg::CC_W-1:0];
                renc_pkg::REG_CC1:     cfg_reg.cc[1]   <= pwdata[renc_pkg::CC_W-1:0];
                renc_pkg::REG_CC2:     cfg_reg.cc[2]   <= pwdata[renc_pkg::CC_W-1:0];
                renc_pkg::REG_CC3:     cfg_reg.cc[3]   <= pwdata[renc_pkg::CC_W-1:0];
                renc_pkg::REG_CHANNEL: cfg_reg.channel <= pwdata[renc_pkg::CHAN_W-1:0];
                renc_pkg::REG_STEP:    step_reg        <= pwdata[renc_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        prdata = '0;
        unique case (widx)
            renc_pkg::REG_CC0:     prdata = {25'd0, cfg_reg.cc[0]};
            renc_pkg::REG_CC1:     prdata = {25'd0, cfg_reg.cc[1]};
            renc_pkg::REG_CC2:     prdata = {25'd0, cfg_reg.cc[2]};
            renc_pkg::REG_CC3:     prdata = {25'd0, cfg_reg.cc[3]};
            renc_pkg::REG_CHANNEL: prdata = {28'd0, cfg_reg.channel};
            renc_pkg::REG_STEP:    prdata = {19'd0, step_reg};
            default:               prdata = '0;
        endcase
    end

    // input transfer and previous sample
    assign s_tready = take_ready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pins_reg <= renc_pkg::PINS_RESET;
        end else if (accept) begin
            prev_pins_reg <= s_tdata;
        end
    end

    // one lane per present encoder
    for (genvar k = 0; k < renc_pkg::ENC_MAX; k++) begin : g_lane
        if (k < ENCODER_COUNT) begin : g_on
            renc_lane u_lane (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .accept      (accept),
                .pair_before (prev_pins_reg[2*k+1:2*k]),
                .pair_now    (s_tdata[2*k+1:2*k]),
                .step        (step_reg),
                .stat        (lane_stat[k])
            );
        end else begin : g_off
            assign lane_stat[k] = '0;
        end
    end

    renc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .lane_stat  (lane_stat),
        .cfg        (cfg_reg),
        .take_ready (take_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
